// ===== design/drf_pkg.sv =====
// Package for the decimal round-to-fit core: word types, sizes, codes and helpers.
// No dependencies; used by drf_div10, decimal_round_to_fit_core and the bench.
package drf_pkg;

  localparam int WORD_W     = 32;
  localparam int MANT_WORDS = 7;
  localparam int FIT_WORDS  = 3;
  localparam int SCALE_W    = 8;
  localparam int REM_W      = 4;

  // Reciprocal of ten for a 36-bit dividend: floor(2^36 / 10).
  localparam int          RECIP_SHIFT = 36;
  localparam logic [32:0] RECIP_TEN   = 33'd6871947673;

  // Commands.
  localparam logic CMD_ROUND = 1'b0;
  localparam logic CMD_STRIP = 1'b1;

  // Status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_POS_OVF = 2'd1;
  localparam logic [1:0] STATUS_NEG_OVF = 2'd2;

  typedef logic [MANT_WORDS-1:0][WORD_W-1:0] mant_t;

  typedef struct packed {
    logic               command;
    logic [WORD_W-1:0]  mant_w0;
    logic [WORD_W-1:0]  mant_w1;
    logic [WORD_W-1:0]  mant_w2;
    logic [WORD_W-1:0]  mant_w3;
    logic [WORD_W-1:0]  mant_w4;
    logic [WORD_W-1:0]  mant_w5;
    logic [WORD_W-1:0]  mant_w6;
    logic [SCALE_W-1:0] scale_in;
    logic               sign_in;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0]  res_w0;
    logic [WORD_W-1:0]  res_w1;
    logic [WORD_W-1:0]  res_w2;
    logic [SCALE_W-1:0] scale_out;
    logic               sign_out;
    logic [1:0]         status;
  } out_word_t;

  // True when any mantissa bit at or above bit 96 is set.
  function automatic logic over_fit(mant_t m);
    return |m[MANT_WORDS-1:FIT_WORDS];
  endfunction

endpackage

// ===== design/drf_div10.sv =====
// Shared divide-by-ten unit: divides {remainder, 32-bit word} by ten combinationally.
// Depends on drf_pkg for widths and the reciprocal constant.
module drf_div10 (
  input  logic [drf_pkg::REM_W-1:0]  rem_in,
  input  logic [drf_pkg::WORD_W-1:0] word_in,
  output logic [drf_pkg::WORD_W-1:0] quot,
  output logic [drf_pkg::REM_W-1:0]  rem_out
);

  localparam int CUR_W  = drf_pkg::REM_W + drf_pkg::WORD_W;
  localparam int PROD_W = CUR_W + 33;

  logic [CUR_W-1:0]          cur;
  logic [PROD_W-1:0]         prod;
  logic [drf_pkg::WORD_W-1:0] q_est;
  logic [CUR_W-1:0]          q_ext;
  logic [CUR_W-1:0]          r_full;
  logic [4:0]                r_est;

  // The reciprocal estimate is the true quotient or one below it.
  assign cur    = {rem_in, word_in};
  assign prod   = PROD_W'(cur) * PROD_W'(drf_pkg::RECIP_TEN);
  assign q_est  = prod[drf_pkg::RECIP_SHIFT +: drf_pkg::WORD_W];
  assign q_ext  = CUR_W'(q_est);
  assign r_full = cur - (q_ext << 3) - (q_ext << 1);
  assign r_est  = r_full[4:0];

  // One compare and subtract corrects the estimate.
  always_comb begin
    if (r_est >= 5'd10) begin
      quot    = q_est + 32'd1;
      rem_out = 4'(r_est - 5'd10);
    end else begin
      quot    = q_est;
      rem_out = r_est[3:0];
    end
  end

endmodule

// ===== design/decimal_round_to_fit_core.sv =====
// Decimal round-to-fit core: top level with the step sequencer and mantissa registers.
// Depends on drf_pkg and drf_div10.
//
// One word in, one word out. The core divides a 224-bit mantissa by ten one 32-bit
// word per cycle through a single reciprocal divider; each divide-by-ten step passes
// all seven words through ST_DIV, then rounds or commits in ST_DECIDE and tests the
// loop in ST_CHECK. The number of steps is at most scale_in (round: digits removed;
// strip: zeros removed plus the one failed test).
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register while the next word is accepted.
module decimal_round_to_fit_core #(
  parameter int MAX_SCALE = 28
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  drf_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output drf_pkg::out_word_t  out_data
);

  localparam logic [drf_pkg::SCALE_W-1:0] MAX_SCALE_V = drf_pkg::SCALE_W'(MAX_SCALE);
  localparam logic [2:0] LAST_IDX = 3'(drf_pkg::MANT_WORDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DECIDE,
    ST_FIN
  } state_t;

  state_t                        state_r, state_nxt;
  drf_pkg::mant_t                m_r, m_nxt;
  drf_pkg::mant_t                q_r, q_nxt;
  logic [drf_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [2:0]                    idx_r, idx_nxt;
  logic [drf_pkg::SCALE_W-1:0]   scale_r, scale_nxt;
  logic                          sign_r, sign_nxt;
  logic                          cmd_r, cmd_nxt;
  logic                          out_valid_r, out_valid_nxt;
  drf_pkg::out_word_t            out_data_r, out_data_nxt;

  logic [drf_pkg::WORD_W-1:0]    div_quot;
  logic [drf_pkg::REM_W-1:0]     div_rem;
  logic [drf_pkg::SCALE_W-1:0]   scale_dec;
  logic                          round_up;

  // Shared divider always sees the top word of the rotating mantissa.
  drf_div10 u_div10 (
    .rem_in  (rem_r),
    .word_in (m_r[drf_pkg::MANT_WORDS-1]),
    .quot    (div_quot),
    .rem_out (div_rem)
  );

  assign scale_dec = scale_r - 8'd1;

  // Rounding applies only on the step that leaves the value in range.
  always_comb begin
    round_up = 1'b0;
    if (!drf_pkg::over_fit(q_r) && scale_dec <= MAX_SCALE_V) begin
      round_up = (rem_r > 4'd5) || (rem_r == 4'd5 && q_r[0][0]);
    end
  end

  // Sequencer next-state and datapath.
  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    scale_nxt     = scale_r;
    sign_nxt      = sign_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          m_nxt     = {in_data.mant_w6, in_data.mant_w5, in_data.mant_w4, in_data.mant_w3,
                       in_data.mant_w2, in_data.mant_w1, in_data.mant_w0};
          scale_nxt = in_data.scale_in;
          sign_nxt  = in_data.sign_in;
          cmd_nxt   = in_data.command;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        rem_nxt = '0;
        idx_nxt = '0;
        if (scale_r != '0 &&
            (cmd_r == drf_pkg::CMD_STRIP || drf_pkg::over_fit(m_r) || scale_r > MAX_SCALE_V)) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        // Rotate the mantissa so it is intact after all seven words pass; quotient shifts in.
        m_nxt   = {m_r[drf_pkg::MANT_WORDS-2:0], m_r[drf_pkg::MANT_WORDS-1]};
        q_nxt   = {q_r[drf_pkg::MANT_WORDS-2:0], div_quot};
        rem_nxt = div_rem;
        idx_nxt = idx_r + 3'd1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (cmd_r == drf_pkg::CMD_ROUND) begin
          m_nxt     = round_up ? drf_pkg::mant_t'(q_r + drf_pkg::mant_t'(1)) : q_r;
          scale_nxt = scale_dec;
          state_nxt = ST_CHECK;
        end else if (rem_r == '0) begin
          m_nxt     = q_r;
          scale_nxt = scale_dec;
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.res_w0    = m_r[0];
          out_data_nxt.res_w1    = m_r[1];
          out_data_nxt.res_w2    = m_r[2];
          out_data_nxt.scale_out = scale_r;
          out_data_nxt.sign_out  = sign_r;
          if (!drf_pkg::over_fit(m_r)) begin
            out_data_nxt.status = drf_pkg::STATUS_OK;
          end else if (sign_r) begin
            out_data_nxt.status = drf_pkg::STATUS_NEG_OVF;
          end else begin
            out_data_nxt.status = drf_pkg::STATUS_POS_OVF;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs; only control state is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    m_r        <= m_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    scale_r    <= scale_nxt;
    sign_r     <= sign_nxt;
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The running remainder is always a decimal digit.
  a_rem_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_DECIDE) |-> rem_r < 4'd10)
    else $error("remainder out of digit range");

  // The scale never grows while a word is being worked on.
  a_scale_falls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && $past(state_r) == ST_DECIDE) |-> scale_r <= $past(scale_r))
    else $error("scale increased during processing");

  // An accepted word blocks the input for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after acceptance");

  // No result carries the unused status code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == drf_pkg::STATUS_OK ||
                   out_data.status == drf_pkg::STATUS_POS_OVF ||
                   out_data.status == drf_pkg::STATUS_NEG_OVF))
    else $error("invalid status code");

endmodule

// ===== bench/tb_decimal_round_to_fit_core.sv =====
// Self-checking bench for decimal_round_to_fit_core: directed and random words on both channels.
// Depends on drf_pkg and the core; expected words come from an in-bench bit-exact predictor.
module tb_decimal_round_to_fit_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIT_SCALE      = 28;
  localparam int RANDOM_WORDS   = 400;
  localparam int CALM_WORDS     = 60;
  // Drain tail sized for the slowest word, one with scale 255.
  localparam int TAIL_CYCLES    = 2400;
  localparam int HOLD_CYCLES    = 600;
  localparam int HOLD_AFTER     = 100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_SHOWN      = 10;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  drf_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  drf_pkg::out_word_t out_data;

  bit          idle_on = 1'b1;
  int unsigned in_sent = 0;

  decimal_round_to_fit_core #(.MAX_SCALE(FIT_SCALE)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Holds the fitted words still owed by the core and compares each arriving word.
  class fit_checker;
    drf_pkg::out_word_t fitted_q[$];
    int unsigned        mismatches = 0;
    int unsigned        seen = 0;

    // Bit-exact fit of one input word.
    static function drf_pkg::out_word_t fit_mantissa(drf_pkg::in_word_t w);
      logic [223:0]       m;
      logic [3:0]         digit;
      int                 sc;
      drf_pkg::out_word_t r;
      m  = {w.mant_w6, w.mant_w5, w.mant_w4, w.mant_w3, w.mant_w2, w.mant_w1, w.mant_w0};
      sc = w.scale_in;
      if (w.command == drf_pkg::CMD_ROUND) begin
        while (sc > 0 && (m[223:96] != '0 || sc > FIT_SCALE)) begin
          sc--;
          digit = 4'(m % 224'd10);
          m = m / 224'd10;
          // Only the step that brings the value into range rounds.
          if (m[223:96] == '0 && sc <= FIT_SCALE) begin
            if (digit > 4'd5 || (digit == 4'd5 && m[0])) m = m + 224'd1;
          end
        end
      end else begin
        while (sc > 0 && (m % 224'd10) == '0) begin
          m = m / 224'd10;
          sc--;
        end
      end
      r.res_w0    = m[31:0];
      r.res_w1    = m[63:32];
      r.res_w2    = m[95:64];
      r.scale_out = 8'(sc);
      r.sign_out  = w.sign_in;
      if (m[223:96] == '0) r.status = drf_pkg::STATUS_OK;
      else r.status = w.sign_in ? drf_pkg::STATUS_NEG_OVF : drf_pkg::STATUS_POS_OVF;
      return r;
    endfunction

    function void note_input(drf_pkg::in_word_t w);
      fitted_q.push_back(fit_mantissa(w));
    endfunction

    function void check_result(drf_pkg::out_word_t got);
      drf_pkg::out_word_t want;
      seen++;
      if (fitted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected word %0d: %h_%h_%h scale %0d sign %0d status %0d", seen,
                   got.res_w2, got.res_w1, got.res_w0, got.scale_out, got.sign_out, got.status);
        return;
      end
      want = fitted_q.pop_front();
      if (got.res_w0 !== want.res_w0 || got.res_w1 !== want.res_w1 ||
          got.res_w2 !== want.res_w2 || got.scale_out !== want.scale_out ||
          got.sign_out !== want.sign_out || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("word %0d expected %h_%h_%h scale %0d sign %0d status %0d", seen,
                   want.res_w2, want.res_w1, want.res_w0, want.scale_out, want.sign_out,
                   want.status);
          $display("word %0d actual   %h_%h_%h scale %0d sign %0d status %0d", seen,
                   got.res_w2, got.res_w1, got.res_w0, got.scale_out, got.sign_out,
                   got.status);
        end
      end
    endfunction

    function int unsigned pending();
      return fitted_q.size();
    endfunction
  endclass

  fit_checker sb = new();

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic drf_pkg::in_word_t make_word(logic cmd, logic [223:0] m, int scale,
                                                  logic sign);
    drf_pkg::in_word_t w;
    w.command  = cmd;
    w.mant_w0  = m[31:0];
    w.mant_w1  = m[63:32];
    w.mant_w2  = m[95:64];
    w.mant_w3  = m[127:96];
    w.mant_w4  = m[159:128];
    w.mant_w5  = m[191:160];
    w.mant_w6  = m[223:192];
    w.scale_in = 8'(scale);
    w.sign_in  = sign;
    return w;
  endfunction

  function automatic logic [223:0] pow10(int d);
    logic [223:0] p;
    p = 224'd1;
    repeat (d) p = p * 224'd10;
    return p;
  endfunction

  // Random value with at most the given number of significant bits.
  function automatic logic [223:0] rand_wide(int width);
    logic [223:0] v;
    logic [223:0] one;
    one = 224'd1;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return v & ((one << width) - one);
  endfunction

  // Mostly small scales; a few reach the top of the 8-bit range.
  function automatic int pick_scale();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return $urandom_range(0, 40);
    if (pick < 95) return $urandom_range(41, 80);
    return $urandom_range(81, 255);
  endfunction

  // Offers one word, optionally after an idle burst, and waits for its acceptance.
  task automatic send_word(input drf_pkg::in_word_t w);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    in_sent++;
  endtask

  // Builds one random word: mostly well-formed values that exercise the fitting loops.
  task automatic send_random_word();
    logic [223:0] m;
    logic [223:0] core;
    logic         cmd;
    int           scale;
    int           d;
    int           pick;
    cmd   = ($urandom_range(0, 9) < 6) ? drf_pkg::CMD_ROUND : drf_pkg::CMD_STRIP;
    scale = pick_scale();
    pick  = $urandom_range(0, 99);
    if (cmd == drf_pkg::CMD_ROUND) begin
      if (pick < 75) begin
        // A 96-bit core with d extra digits below it.
        d    = $urandom_range(0, (scale < 38) ? scale : 38);
        core = rand_wide($urandom_range(1, 96));
        if ($urandom_range(0, 9) == 0) core = {128'd0, {96{1'b1}}};
        m = core * pow10(d) + (rand_wide(224) % pow10(d));
      end else begin
        m = rand_wide($urandom_range(1, 224));
      end
    end else begin
      if (pick < 80) begin
        d = $urandom_range(0, (scale + 2 < 60) ? scale + 2 : 60);
        m = rand_wide($urandom_range(1, 100)) * pow10(d);
      end else if (pick < 95) begin
        m = rand_wide($urandom_range(1, 224));
      end else begin
        m = '0;
      end
    end
    send_word(make_word(cmd, m, scale, 1'($urandom_range(0, 1))));
  endtask

  // Receiver: checks accepted words and drives out_ready with bursts and one long hold-off.
  initial begin
    int  stall;
    int  hold;
    bit  hold_done;
    stall     = 0;
    hold      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_valid && out_ready) sb.check_result(out_data);
        if (!hold_done && in_sent >= HOLD_AFTER) begin
          hold_done = 1'b1;
          hold      = HOLD_CYCLES;
        end
        if (hold > 0) begin
          hold--;
          out_ready <= 1'b0;
        end else if (stall > 0) begin
          stall--;
          out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          stall = $urandom_range(1, 11) - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed words, random words, drain.
  initial begin
    logic [223:0] ones;
    logic [223:0] fit_max;
    ones    = '1;
    fit_max = {128'd0, {96{1'b1}}};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Round: zero, full-width overflow of each sign, and the longest possible loop.
    send_word(make_word(drf_pkg::CMD_ROUND, '0, 0, 1'b0));
    send_word(make_word(drf_pkg::CMD_ROUND, ones, 0, 1'b0));
    send_word(make_word(drf_pkg::CMD_ROUND, ones, 0, 1'b1));
    send_word(make_word(drf_pkg::CMD_ROUND, ones, 255, 1'b1));
    // Round: largest fitting value left alone, then forced down by one digit of scale.
    send_word(make_word(drf_pkg::CMD_ROUND, fit_max, FIT_SCALE, 1'b0));
    send_word(make_word(drf_pkg::CMD_ROUND, fit_max, FIT_SCALE + 1, 1'b1));
    // Round: rounding up carries into bit 96, so the loop keeps dividing while scale remains, else it overflows.
    send_word(make_word(drf_pkg::CMD_ROUND, fit_max * 224'd10 + 224'd5, 5, 1'b0));
    send_word(make_word(drf_pkg::CMD_ROUND, fit_max * 224'd10 + 224'd7, 1, 1'b1));
    // Round: ties go to even, digits above five round up, below five truncate.
    send_word(make_word(drf_pkg::CMD_ROUND, 224'd25, FIT_SCALE + 1, 1'b0));
    send_word(make_word(drf_pkg::CMD_ROUND, 224'd35, FIT_SCALE + 1, 1'b0));
    send_word(make_word(drf_pkg::CMD_ROUND, 224'd36, FIT_SCALE + 1, 1'b0));
    send_word(make_word(drf_pkg::CMD_ROUND, 224'd34, FIT_SCALE + 1, 1'b0));
    // Round: earlier dropped digits do not influence the final rounding.
    send_word(make_word(drf_pkg::CMD_ROUND, 224'd2499, FIT_SCALE + 3, 1'b0));
    send_word(make_word(drf_pkg::CMD_ROUND, fit_max * 224'd1000 + 224'd499, 10, 1'b0));
    // Strip: zero mantissa runs the scale down to zero; others lose trailing zeros until scale zero or a nonzero digit.
    send_word(make_word(drf_pkg::CMD_STRIP, '0, 255, 1'b0));
    send_word(make_word(drf_pkg::CMD_STRIP, 224'd1000, 2, 1'b0));
    send_word(make_word(drf_pkg::CMD_STRIP, 224'd1000, 5, 1'b1));
    send_word(make_word(drf_pkg::CMD_STRIP, 224'd123457, 10, 1'b0));
    // Strip: overflow check applies to the stripped value as well.
    send_word(make_word(drf_pkg::CMD_STRIP, ones, 0, 1'b0));
    send_word(make_word(drf_pkg::CMD_STRIP, ones, 200, 1'b1));
    send_word(make_word(drf_pkg::CMD_STRIP, pow10(60), 70, 1'b0));
    send_word(make_word(drf_pkg::CMD_STRIP, pow10(60), 20, 1'b1));

    // Random words; the final stretch runs without idling on either side.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - CALM_WORDS) idle_on = 1'b0;
      send_random_word();
    end
    in_valid <= 1'b0;

    // Drain, then give the core time to show any stray word.
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/drf_pkg.sv
design/drf_div10.sv
design/decimal_round_to_fit_core.sv
bench/tb_decimal_round_to_fit_core.sv
